/* hw/rtl/nfd_pkg.sv */
// ----------------------------------------------------------------------------
// nfd_pkg
// Shared types and constants of the notch filter tone detector.
// ----------------------------------------------------------------------------
`default_nettype none

package nfd_pkg;

   // Datapath widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 17;
   localparam int C2_W     = 15;
   localparam int Y_W      = 48;
   localparam int DIGIT_W  = 8;
   localparam int NDIG_A   = SAMPLE_W / DIGIT_W;

   // Energy and count
   localparam int ENERGY_W = 24;
   localparam int ABS_W    = SAMPLE_W + 1;
   localparam int COUNT_W  = 9;
   localparam int THR_W    = COUNT_W + 9;
   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
   localparam int MIN_ENERGY     = 500;
   localparam int WINDOW_SAMPLES = 40;

   // Tone status codes
   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_ABSENT  = 2'd1;
   localparam logic [1:0] STATUS_PRESENT = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_FF  = 2'd0;
   localparam logic [1:0] REG_FB2 = 2'd1;
   localparam logic [1:0] REG_FB1 = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FF,
      ST_MUL_FB2,
      ST_MUL_FB1,
      ST_SUM,
      ST_ENERGY,
      ST_DECIDE
   } state_type;

   // Sequencer controls for the digit-serial multiply-accumulate
   typedef struct packed {
      logic start;
      logic load;
      logic step;
      logic first;
   } mac_ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/nfd_mac.sv */
// ----------------------------------------------------------------------------
// nfd_mac
// Digit-serial multiply-accumulate: the coefficient stays parallel, the
// operand shifts out MSB digit first, products sum modulo 2^48.
// ----------------------------------------------------------------------------
`default_nettype none

module nfd_mac
   import nfd_pkg::*;
#(
   parameter int OP_W = 40
)
(
   input  wire logic                     clock,
   input  wire mac_ctrl_type             ctrl,
   input  wire logic signed [COEF_W-1:0] coeff,
   input  wire logic [OP_W-1:0]          operand,
   input  wire logic [Y_W-1:0]           init,
   output logic [Y_W-1:0]                y
);

   localparam int PROD_W = COEF_W + DIGIT_W + 1;

   logic [OP_W-1:0]          op_ff, op_in;
   logic [Y_W-1:0]           p_ff, p_in;
   logic [Y_W-1:0]           s_ff, s_in;
   logic [DIGIT_W-1:0]       digit;
   logic signed [DIGIT_W:0]  digit_ext;
   logic signed [PROD_W-1:0] prod;
   logic [Y_W-1:0]           prod_ext;

   // Top digit of each operand is signed, the rest unsigned
   assign digit     = op_ff[OP_W-1 -: DIGIT_W];
   assign digit_ext = ctrl.first ? signed'({digit[DIGIT_W-1], digit})
                                 : signed'({1'b0, digit});
   assign prod      = coeff * digit_ext;
   assign prod_ext  = {{(Y_W-PROD_W){prod[PROD_W-1]}}, prod};

   // Partial product, running sum and operand shifter
   always_comb begin
      op_in = op_ff;
      p_in  = p_ff;
      s_in  = s_ff;
      if (ctrl.start || ctrl.load) begin
         op_in = operand;
      end else if (ctrl.step) begin
         op_in = op_ff << DIGIT_W;
      end
      if (ctrl.start) begin
         p_in = '0;
         s_in = init;
      end else if (ctrl.step) begin
         if (ctrl.first) begin
            // previous product is complete: fold it into the sum
            p_in = prod_ext;
            s_in = s_ff + p_ff;
         end else begin
            p_in = (p_ff << DIGIT_W) + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      p_ff  <= p_in;
      s_ff  <= s_in;
   end

   assign y = s_ff + p_ff;

endmodule

`default_nettype wire

/* hw/rtl/notch_filter_tone_detector.sv */
// ----------------------------------------------------------------------------
// notch_filter_tone_detector: IIR notch filter with tone detection
// Each request steps through the multiply states FF, FB2 and FB1 on the
//   8-bit digit-serial multiplier, then SUM, ENERGY and DECIDE.
// A new request is taken only back in IDLE, after the response is registered.
// Reset: synchronous; clears filter state, energies, count and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module notch_filter_tone_detector
   import nfd_pkg::*;
#(
   parameter int FRAC_BITS = 14
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_chunk_end,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_filtered_sample,
   output logic [1:0]                      rsp_tone_status,
   // configuration port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]           csr_prdata,
   output logic                            csr_pready
);

   localparam int YS_W   = Y_W - FRAC_BITS;
   localparam int NDIG_Y = (YS_W + DIGIT_W - 1) / DIGIT_W;
   localparam int OP_W   = NDIG_Y * DIGIT_W;
   localparam int DIG_W  = $clog2(NDIG_Y);
   localparam logic [DIG_W-1:0] LAST_A = DIG_W'(NDIG_A - 1);
   localparam logic [DIG_W-1:0] LAST_Y = DIG_W'(NDIG_Y - 1);

   function automatic logic [ABS_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] s);
      logic [ABS_W-1:0] e;
      e = {s[SAMPLE_W-1], s};
      return s[SAMPLE_W-1] ? (~e + ABS_W'(1)) : e;
   endfunction

   function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] acc,
                                                   input logic [ABS_W-1:0]    add);
      logic [ENERGY_W:0] sum;
      sum = {1'b0, acc} + (ENERGY_W+1)'(add);
      return sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [DIG_W-1:0] dig_ff, dig_in;

   logic [COEF_W-1:0] cff_ff, cff_in;
   logic [C2_W-1:0]   c2_ff, c2_in;
   logic [COEF_W-1:0] c1_ff, c1_in;

   logic [SAMPLE_W-1:0] d1_ff, d1_in;
   logic [SAMPLE_W-1:0] d2_ff, d2_in;
   logic signed [Y_W-1:0] y1_ff, y1_in;
   logic signed [Y_W-1:0] y2_ff, y2_in;
   logic [ENERGY_W-1:0] eb_ff, eb_in;
   logic [ENERGY_W-1:0] ea_ff, ea_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                chunk_ff, chunk_in;
   logic [SAMPLE_W-1:0] filt_ff, filt_in;
   logic [THR_W-1:0]    thr_ff, thr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic accept, last_digit, rsp_free, decide, tone;
   logic csr_wr;
   logic [1:0] csr_index;
   mac_ctrl_type mac_ctrl;
   logic signed [COEF_W-1:0] mac_coeff;
   logic [OP_W-1:0] mac_operand;
   logic [Y_W-1:0]  mac_init;
   logic [Y_W-1:0]  y;
   logic signed [Y_W-1:0] ys1, ys2;
   logic [Y_W-1:0] x_ext, d2_ext;
   logic [ENERGY_W:0] after_thr;

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;

   assign last_digit = (state_ff == ST_MUL_FF) ? (dig_ff == LAST_A) : (dig_ff == LAST_Y);

   // Previous outputs scaled down for the feedback products
   assign ys1 = y1_ff >>> FRAC_BITS;
   assign ys2 = y2_ff >>> FRAC_BITS;

   // New input plus input two back, both scaled up
   assign x_ext  = {{(Y_W-SAMPLE_W){req_sample[SAMPLE_W-1]}}, req_sample} << FRAC_BITS;
   assign d2_ext = {{(Y_W-SAMPLE_W){d2_ff[SAMPLE_W-1]}}, d2_ff} << FRAC_BITS;
   assign mac_init = x_ext + d2_ext;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_MUL_FF;
         ST_MUL_FF:  if (last_digit) state_in = ST_MUL_FB2;
         ST_MUL_FB2: if (last_digit) state_in = ST_MUL_FB1;
         ST_MUL_FB1: if (last_digit) state_in = ST_SUM;
         ST_SUM:     state_in = ST_ENERGY;
         ST_ENERGY:  state_in = ST_DECIDE;
         ST_DECIDE:  if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      mac_ctrl       = '0;
      mac_coeff      = '0;
      mac_operand    = {d1_ff, {(OP_W-SAMPLE_W){1'b0}}};
      dig_in         = dig_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            mac_ctrl.start = req_valid;
            mac_ctrl.load  = req_valid;
            dig_in         = '0;
         end
         ST_MUL_FF: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (dig_ff == '0);
            mac_ctrl.load  = last_digit;
            mac_coeff      = signed'(cff_ff);
            mac_operand    = ys2[OP_W-1:0];
            dig_in         = last_digit ? '0 : dig_ff + DIG_W'(1);
         end
         ST_MUL_FB2: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (dig_ff == '0);
            mac_ctrl.load  = last_digit;
            mac_coeff      = signed'({{(COEF_W-C2_W){c2_ff[C2_W-1]}}, c2_ff});
            mac_operand    = ys1[OP_W-1:0];
            dig_in         = last_digit ? '0 : dig_ff + DIG_W'(1);
         end
         ST_MUL_FB1: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (dig_ff == '0);
            mac_coeff      = signed'(c1_ff);
            dig_in         = last_digit ? '0 : dig_ff + DIG_W'(1);
         end
         default: begin
         end
      endcase
   end

   nfd_mac #(
      .OP_W (OP_W)
   ) u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .coeff   (mac_coeff),
      .operand (mac_operand),
      .init    (mac_init),
      .y       (y)
   );

   // Decision: quotient above the floor means diff >= (floor + 1) * count
   assign after_thr = {1'b0, ea_ff} + (ENERGY_W+1)'(thr_ff);
   assign tone      = ({1'b0, eb_ff} >= after_thr);
   assign decide    = chunk_ff && (32'(cnt_ff) >= WINDOW_SAMPLES) && (cnt_ff != '0);

   // Datapath and state updates
   always_comb begin
      cff_in        = cff_ff;
      c2_in         = c2_ff;
      c1_in         = c1_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;
      eb_in         = eb_ff;
      ea_in         = ea_ff;
      cnt_in        = cnt_ff;
      chunk_in      = chunk_ff;
      filt_in       = filt_ff;
      thr_in        = thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_filt_in   = rsp_filt_ff;
      rsp_status_in = rsp_status_ff;

      // configuration writes
      if (csr_wr) begin
         case (csr_index)
            REG_FF:  cff_in = csr_pwdata[COEF_W-1:0];
            REG_FB2: c2_in  = csr_pwdata[C2_W-1:0];
            REG_FB1: c1_in  = csr_pwdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end

      // request taken: input delay line and input energy
      if (accept) begin
         d2_in    = d1_ff;
         d1_in    = req_sample;
         chunk_in = req_chunk_end;
         eb_in    = sat_add(eb_ff, abs_sample(req_sample));
      end

      case (state_ff)
         ST_SUM: begin
            y2_in   = y1_ff;
            y1_in   = signed'(y);
            filt_in = y[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
            if (cnt_ff != COUNT_MAX) begin
               cnt_in = cnt_ff + COUNT_W'(1);
            end
         end
         ST_ENERGY: begin
            ea_in  = sat_add(ea_ff, abs_sample(filt_ff));
            thr_in = THR_W'(cnt_ff * (MIN_ENERGY + 1));
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_filt_in   = filt_ff;
               rsp_status_in = STATUS_NONE;
               if (decide) begin
                  rsp_status_in = tone ? STATUS_PRESENT : STATUS_ABSENT;
                  eb_in         = '0;
                  ea_in         = '0;
                  cnt_in        = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dig_ff       <= '0;
         cff_ff       <= '0;
         c2_ff        <= '0;
         c1_ff        <= '0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         eb_ff        <= '0;
         ea_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dig_ff       <= dig_in;
         cff_ff       <= cff_in;
         c2_ff        <= c2_in;
         c1_ff        <= c1_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         eb_ff        <= eb_in;
         ea_ff        <= ea_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chunk_ff      <= chunk_in;
      filt_ff       <= filt_in;
      thr_ff        <= thr_in;
      rsp_filt_ff   <= rsp_filt_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Register readback
   always_comb begin
      case (csr_index)
         REG_FF:  csr_prdata = CSR_DATA_W'(cff_ff);
         REG_FB2: csr_prdata = CSR_DATA_W'(c2_ff);
         REG_FB1: csr_prdata = CSR_DATA_W'(c1_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = signed'(rsp_filt_ff);
   assign rsp_tone_status     = rsp_status_ff;

endmodule

`default_nettype wire

/* hw/rtl/nfd_checker.sv */
// ----------------------------------------------------------------------------
// nfd_checker
// Port-level checks of the notch filter tone detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nfd_checker
   import nfd_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [SAMPLE_W-1:0] rsp_filtered_sample,
   input wire logic [1:0]                 rsp_tone_status,
   input wire logic                       csr_pready
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_sample)
                                  && $stable(rsp_tone_status))
      else $error("response changed while stalled");

   // one request at a time: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // status is one of the defined codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tone_status == STATUS_NONE ||
                     rsp_tone_status == STATUS_ABSENT ||
                     rsp_tone_status == STATUS_PRESENT))
      else $error("undefined tone status");

   // reset leaves the block empty and ready
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // register port never waits
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind notch_filter_tone_detector nfd_checker u_nfd_checker (.*);

`default_nettype wire

/* tb/sv/tb_notch_filter_tone_detector.sv */
// ----------------------------------------------------------------------------
// tb_notch_filter_tone_detector
// Self-checking bench for the notch filter tone detector. A scoreboard class
// tracks the filter state, energy sums and sample count for every accepted
// request and checks each response against its own prediction. Stimulus runs
// corner samples first, then chunks of tones, noise and full-scale values
// under several coefficient sets, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_notch_filter_tone_detector;
   import nfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC       = 14;
   localparam int HOLD_LONG  = 400;   // long receiver back-pressure, cycles
   localparam int WD_LIMIT   = 2000;  // cycles with no handshake at all
   localparam int TAIL       = 40;    // settle time after the last response

   typedef enum int {CHUNK_TONE, CHUNK_NOISE, CHUNK_FULL, CHUNK_QUIET} chunk_kind_type;

   // Predicts the filter output and tone status per request, holds the results
   class tone_scoreboard;
      logic signed [16:0] ff_coef  = '0;
      logic signed [14:0] fb2_coef = '0;
      logic signed [16:0] fb1_coef = '0;
      longint signed x_prev1 = 0, x_prev2 = 0, y_prev1 = 0, y_prev2 = 0;
      int unsigned sum_in = 0, sum_out = 0, count = 0;
      logic signed [15:0] filt_q[$];
      logic [1:0]         status_q[$];
      int errors = 0;

      function void set_coef(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_FF:  ff_coef  = value[16:0];
            REG_FB2: fb2_coef = value[14:0];
            REG_FB1: fb1_coef = value[16:0];
            default: ;
         endcase
      endfunction

      function int unsigned sat_energy(int unsigned acc, int mag);
         int unsigned total;
         total = acc + int'(mag);
         return (total > ENERGY_MAX) ? int'(ENERGY_MAX) : total;
      endfunction

      function void note_request(logic signed [15:0] samp, logic ce);
         longint signed x_now, acc, diff;
         logic signed [47:0] y, y_shift;
         logic signed [15:0] filt;
         logic [1:0] status;
         status = STATUS_NONE;
         sum_in = sat_energy(sum_in, (samp < 0) ? -int'(samp) : int'(samp));

         // second-order section, state wraps at 48 bits
         x_now = longint'(samp) * (longint'(1) << FRAC);
         acc = x_prev2 + longint'(ff_coef) * (x_prev1 >>> FRAC) + x_now
             + longint'(fb2_coef) * (y_prev2 >>> FRAC)
             + longint'(fb1_coef) * (y_prev1 >>> FRAC);
         y = acc[47:0];
         x_prev2 = x_prev1;
         x_prev1 = x_now;
         y_prev2 = y_prev1;
         y_prev1 = longint'(y);

         y_shift = y >>> FRAC;
         filt = y_shift[15:0];
         sum_out = sat_energy(sum_out, (filt < 0) ? -int'(filt) : int'(filt));
         if (count < COUNT_MAX) count++;

         // decision at a chunk mark once the window is full
         if (ce && count >= WINDOW_SAMPLES) begin
            diff = longint'(sum_in) - longint'(sum_out);
            status = (diff / longint'(count) > MIN_ENERGY) ? STATUS_PRESENT : STATUS_ABSENT;
            count = 0;
            sum_in = 0;
            sum_out = 0;
         end
         filt_q.push_back(filt);
         status_q.push_back(status);
      endfunction

      function void check_response(logic signed [15:0] got_filt, logic [1:0] got_status);
         logic signed [15:0] want_filt;
         logic [1:0] want_status;
         if (filt_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: filtered %0d status %0d",
                     $time, got_filt, got_status);
            return;
         end
         want_filt = filt_q.pop_front();
         want_status = status_q.pop_front();
         if (got_filt !== want_filt) begin
            errors++;
            $display("%0t: filtered_sample mismatch: expected %0d, actual %0d",
                     $time, want_filt, got_filt);
         end
         if (got_status !== want_status) begin
            errors++;
            $display("%0t: tone_status mismatch: expected %0d, actual %0d",
                     $time, want_status, got_status);
         end
      endfunction

      function int pending();
         return filt_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic req_chunk_end = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered_sample;
   logic [1:0] rsp_tone_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   tone_scoreboard sb;
   bit idle_on = 1'b1;
   bit gaps_now = 1'b1;
   bit hold_long = 1'b0;
   int sent_total = 0;

   // corner samples run with the reset coefficients; marks come before the window
   logic [15:0] corner_samples [16] = '{
      16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
      16'h0001, 16'hFFFF, 16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000};
   localparam logic [15:0] CORNER_MARKS = 16'b1000_0001_0000_1000;

   notch_filter_tone_detector #(.FRAC_BITS(FRAC)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .req_chunk_end       (req_chunk_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_tone_status     (rsp_tone_status),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #10 clock = ~clock;

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_filtered_sample, rsp_tone_status);
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      wait (reset == 1'b0);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_LONG) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog on handshake activity
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WD_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: timeout, no handshake for %0d cycles", $time, WD_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function int cos8(int i);
      case (i % 8)
         0: return 1000;
         1: return 707;
         2: return 0;
         3: return -707;
         4: return -1000;
         5: return -707;
         6: return 0;
         default: return 707;
      endcase
   endfunction

   task automatic send_sample(input logic signed [15:0] samp, input logic ce);
      if (idle_on && gaps_now && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= samp;
      req_chunk_end <= ce;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(samp, ce);
      sent_total++;
   endtask

   // One chunk; the last request carries the mark, stray marks are optional
   task automatic send_chunk(input int len, input chunk_kind_type kind, input bit stray);
      int k, ph, amp, v;
      logic ce;
      ph = $urandom_range(0, 7);
      amp = $urandom_range(0, 32767);
      gaps_now = ($urandom_range(0, 2) != 0);
      for (k = 0; k < len; k++) begin
         case (kind)
            CHUNK_TONE:  v = amp * cos8(k + ph) / 1000;
            CHUNK_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
            CHUNK_FULL:  v = $urandom_range(0, 1) ? 32767 : -32768;
            default:     v = int'($urandom_range(0, 4)) - 2;
         endcase
         ce = (k == len - 1) || (stray && $urandom_range(0, 63) == 0);
         send_sample(16'(v), ce);
      end
   endtask

   task automatic run_phase(input int n_items, input bit with_tones);
      int start, len, pick;
      chunk_kind_type kind;
      start = sent_total;
      while (sent_total - start < n_items) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(40, 96) : $urandom_range(1, 39);
         // the last chunk of a phase stops at the phase length
         if (len > n_items - (sent_total - start))
            len = n_items - (sent_total - start);
         pick = $urandom_range(0, 99);
         if (with_tones && pick < 40) kind = CHUNK_TONE;
         else if (pick < 75) kind = CHUNK_NOISE;
         else if (pick < 85) kind = CHUNK_FULL;
         else kind = CHUNK_QUIET;
         send_chunk(len, kind, 1'b1);
      end
   endtask

   task automatic write_coef(input logic [1:0] idx, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_coef(idx, value);
      // leave the bus idle between transfers
      @(posedge clock);
   endtask

   task automatic set_coefs(input int ff, input int fb2, input int fb1);
      write_coef(REG_FF, ff);
      write_coef(REG_FB2, fb2);
      write_coef(REG_FB1, fb1);
   endtask

   // Let every outstanding response come back before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      int i;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 16; i++)
         send_sample(corner_samples[i], CORNER_MARKS[i]);

      // notch at fs/8, r near 0.96; receiver holds off at the start
      wait_drained();
      set_coefs(-23170, -15099, 22243);
      hold_long = 1'b1;
      run_phase(120, 1'b1);

      // coefficient extremes, unstable feedback wraps the state
      wait_drained();
      set_coefs(-32768, -16384, 32768);
      run_phase(80, 1'b1);

      // opposite extremes; a long full-scale run marked only at its end saturates count and energy
      wait_drained();
      set_coefs(32768, 0, -32768);
      send_chunk(540, CHUNK_FULL, 1'b0);
      run_phase(40, 1'b0);

      wait_drained();
      set_coefs(0, 0, 0);
      run_phase(60, 1'b1);

      repeat (4) begin
         wait_drained();
         set_coefs(int'($urandom_range(0, 65536)) - 32768, -int'($urandom_range(0, 16384)),
                   int'($urandom_range(0, 65536)) - 32768);
         run_phase(80, 1'b1);
      end

      // closing stretch at full rate
      wait_drained();
      idle_on = 1'b0;
      set_coefs(-23170, -15099, 22243);
      run_phase(150, 1'b1);

      wait_drained();
      repeat (TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
